// ----- rtl/chm_pkg.sv -----
// Shared types and widths for the chained hash map.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package chm_pkg;

   // Sizing of the map
   localparam int BUCKETS = 16;
   localparam int NODES   = 64;

   // Field widths
   localparam int OP_W   = 2;
   localparam int KEY_W  = 31;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;

   // Derived widths: a link holds a node index or the null code NODES
   localparam int BKT_W  = $clog2(BUCKETS);
   localparam int NODE_W = $clog2(NODES);
   localparam int LINK_W = $clog2(NODES + 1);

   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NODES);

   localparam logic [BKT_W-1:0]        BKT_LAST  = BKT_W'(BUCKETS - 1);
   localparam logic signed [VAL_W-1:0] FV_NONE   = {VAL_W{1'b1}};

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      RS_DONE      = 2'd0,
      RS_NOT_FOUND = 2'd1,
      RS_POOL_FULL = 2'd2
   } resp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_HEAD,
      S_DISPATCH,
      S_NODE_RD,
      S_NODE_CHK,
      S_DEL_FREE,
      S_REPLY
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic clr_step;
      logic head_rd;
      logic ins_wr;
      logic set_full;
      logic walk_start;
      logic node_rd;
      logic walk_adv;
      logic set_found;
      logic del_link;
      logic del_free;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_type op;
      logic   clr_last;
      logic   pool_empty;
      logic   cur_nil;
      logic   key_match;
      logic   out_free;
   } status_type;

endpackage

// ----- rtl/chm_req_if.sv -----
// Request channel of the chained hash map: valid/ready plus the request word.
// Depends on chm_pkg for field widths.
interface chm_req_if;
   logic                                valid;
   logic                                ready;
   logic [chm_pkg::OP_W-1:0]            req_type;
   logic [chm_pkg::KEY_W-1:0]           req_key;
   logic signed [chm_pkg::VAL_W-1:0]    req_value;

   modport source (output valid, req_type, req_key, req_value, input ready);
   modport sink   (input valid, req_type, req_key, req_value, output ready);
endinterface

// ----- rtl/chm_rsp_if.sv -----
// Response channel of the chained hash map: valid/ready plus the result word.
// Depends on chm_pkg for field widths.
interface chm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [chm_pkg::STAT_W-1:0]          status;
   logic signed [chm_pkg::VAL_W-1:0]    found_value;

   modport source (output valid, status, found_value, input ready);
   modport sink   (input valid, status, found_value, output ready);
endinterface

// ----- rtl/chained_hash_map.sv -----
// Chained hash map: insert, search and delete of key/value pairs, bucket =
// key mod BUCKETS, nodes from a pool of NODES. Every request word gives one
// response word with status done, not found or pool full. After reset the
// block clears all BUCKETS entries of its bucket head memory before taking a
// request. An insert goes through accept, bucket head read, link and hand-over
// to the output register. A search or delete adds a node read, then a compare,
// for each chain node visited, since the node memories have one read and one
// write port; a miss adds a step to see the end of the chain and a delete a
// step to return the node to the pool. A response waits in an output register,
// so a new request is taken as soon as the previous one has been handed to
// that register; the hand-over waits while that register still holds a word
// that has not been taken.
// Depends on chm_pkg, chm_req_if, chm_rsp_if, chm_ctrl and chm_datapath.
module chained_hash_map (
   input  logic      clock,
   input  logic      reset,
   chm_req_if.sink   req_ch,
   chm_rsp_if.source rsp_ch
);

   chm_pkg::cmd_type    cmd;
   chm_pkg::status_type sts;

   // Sequencer
   chm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Memories and registers
   chm_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_ch.req_type),
      .req_key         (req_ch.req_key),
      .req_value       (req_ch.req_value),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_found_value (rsp_ch.found_value)
   );

endmodule

// ----- rtl/chm_datapath.sv -----
// Datapath of the chained hash map: bucket and node memories, free pool, bucket
// selection, chain walk registers and the response register. Depends on chm_pkg.
module chm_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  chm_pkg::cmd_type                 cmd,
   output chm_pkg::status_type              sts,
   input  logic [chm_pkg::OP_W-1:0]         req_type,
   input  logic [chm_pkg::KEY_W-1:0]        req_key,
   input  logic signed [chm_pkg::VAL_W-1:0] req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [chm_pkg::STAT_W-1:0]       rsp_status,
   output logic signed [chm_pkg::VAL_W-1:0] rsp_found_value
);

   // Memories
   logic [chm_pkg::LINK_W-1:0] bucket_mem [chm_pkg::BUCKETS];
   logic [chm_pkg::KEY_W-1:0]  key_mem    [chm_pkg::NODES];
   logic [chm_pkg::VAL_W-1:0]  value_mem  [chm_pkg::NODES];
   logic [chm_pkg::LINK_W-1:0] next_mem   [chm_pkg::NODES];

   // Request word
   chm_pkg::op_type                 op_ff;
   logic [chm_pkg::KEY_W-1:0]       key_ff;
   logic [chm_pkg::VAL_W-1:0]       value_ff;

   // Bucket of the request
   logic [chm_pkg::BKT_W-1:0]       bucket_ff;

   // Clearing pass over the bucket heads
   logic [chm_pkg::BKT_W-1:0]       clr_ff;

   // Free pool: explicit list head plus the boundary of never-used nodes
   logic [chm_pkg::LINK_W-1:0]      free_head_ff;
   logic [chm_pkg::LINK_W-1:0]      fresh_ff;

   // Chain walk
   logic [chm_pkg::LINK_W-1:0]      cur_ff;
   logic [chm_pkg::LINK_W-1:0]      prev_ff;

   // Registered read data
   logic [chm_pkg::LINK_W-1:0]      head_rdata_ff;
   logic [chm_pkg::LINK_W-1:0]      next_rdata_ff;
   logic [chm_pkg::KEY_W-1:0]       key_rdata_ff;
   logic [chm_pkg::VAL_W-1:0]       value_rdata_ff;

   // Result scratch and output register
   chm_pkg::resp_type               res_status_ff;
   logic [chm_pkg::VAL_W-1:0]       res_fv_ff;
   logic                            rsp_valid_ff;
   logic [chm_pkg::STAT_W-1:0]      rsp_status_ff;
   logic [chm_pkg::VAL_W-1:0]       rsp_fv_ff;

   // Write port controls
   logic                            bh_we;
   logic [chm_pkg::BKT_W-1:0]       bh_waddr;
   logic [chm_pkg::LINK_W-1:0]      bh_wdata;
   logic                            nn_we;
   logic [chm_pkg::NODE_W-1:0]      nn_waddr;
   logic [chm_pkg::LINK_W-1:0]      nn_wdata;
   logic [chm_pkg::NODE_W-1:0]      nn_raddr;
   logic [chm_pkg::NODE_W-1:0]      free_idx;
   logic [chm_pkg::NODE_W-1:0]      cur_idx;
   logic                            prev_nil;

   assign free_idx = free_head_ff[chm_pkg::NODE_W-1:0];
   assign cur_idx  = cur_ff[chm_pkg::NODE_W-1:0];
   assign prev_nil = (prev_ff == chm_pkg::NIL_LINK);

   // Request capture; BUCKETS is a power of two, so the modulo is a mask
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= chm_pkg::op_type'(req_type);
         key_ff    <= req_key;
         value_ff  <= req_value;
         bucket_ff <= chm_pkg::BKT_W'(req_key % chm_pkg::BUCKETS);
      end
   end

   // Clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + chm_pkg::BKT_W'(1);
      end
   end

   // Bucket head memory port
   always_comb begin
      bh_we    = cmd.clr_step | cmd.ins_wr | (cmd.del_link & prev_nil);
      bh_waddr = cmd.clr_step ? clr_ff : bucket_ff;
      if (cmd.clr_step) begin
         bh_wdata = chm_pkg::NIL_LINK;
      end else if (cmd.ins_wr) begin
         bh_wdata = free_head_ff;
      end else begin
         bh_wdata = next_rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (bh_we) begin
         bucket_mem[bh_waddr] <= bh_wdata;
      end
      if (cmd.head_rd) begin
         head_rdata_ff <= bucket_mem[bucket_ff];
      end
   end

   // Node link memory port
   always_comb begin
      nn_we = cmd.ins_wr | (cmd.del_link & ~prev_nil) | cmd.del_free;
      if (cmd.ins_wr) begin
         nn_waddr = free_idx;
         nn_wdata = head_rdata_ff;
      end else if (cmd.del_link) begin
         nn_waddr = prev_ff[chm_pkg::NODE_W-1:0];
         nn_wdata = next_rdata_ff;
      end else begin
         nn_waddr = cur_idx;
         nn_wdata = free_head_ff;
      end
      nn_raddr = cmd.head_rd ? free_idx : cur_idx;
   end

   always_ff @(posedge clock) begin
      if (nn_we) begin
         next_mem[nn_waddr] <= nn_wdata;
      end
      if (cmd.head_rd | cmd.node_rd) begin
         next_rdata_ff <= next_mem[nn_raddr];
      end
   end

   // Node key and value memories
   always_ff @(posedge clock) begin
      if (cmd.ins_wr) begin
         key_mem[free_idx]   <= key_ff;
         value_mem[free_idx] <= value_ff;
      end
      if (cmd.node_rd) begin
         key_rdata_ff   <= key_mem[cur_idx];
         value_rdata_ff <= value_mem[cur_idx];
      end
   end

   // Free pool; a never-used node links implicitly to the next index
   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         fresh_ff     <= '0;
      end else if (cmd.ins_wr) begin
         if (free_head_ff == fresh_ff) begin
            free_head_ff <= free_head_ff + chm_pkg::LINK_W'(1);
            fresh_ff     <= fresh_ff + chm_pkg::LINK_W'(1);
         end else begin
            free_head_ff <= next_rdata_ff;
         end
      end else if (cmd.del_free) begin
         free_head_ff <= cur_ff;
      end
   end

   // Chain walk
   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         cur_ff  <= head_rdata_ff;
         prev_ff <= chm_pkg::NIL_LINK;
      end else if (cmd.walk_adv) begin
         cur_ff  <= next_rdata_ff;
         prev_ff <= cur_ff;
      end
   end

   // Result scratch
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         res_status_ff <= chm_pkg::RS_NOT_FOUND;
         res_fv_ff     <= chm_pkg::FV_NONE;
      end else if (cmd.set_full) begin
         res_status_ff <= chm_pkg::RS_POOL_FULL;
      end else if (cmd.set_found) begin
         res_status_ff <= chm_pkg::RS_DONE;
         res_fv_ff     <= value_rdata_ff;
      end else if (cmd.ins_wr | cmd.del_free) begin
         res_status_ff <= chm_pkg::RS_DONE;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_fv_ff     <= res_fv_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_fv_ff;

   // Status back to the controller
   always_comb begin
      sts.op         = op_ff;
      sts.clr_last   = (clr_ff == chm_pkg::BKT_LAST);
      sts.pool_empty = (free_head_ff == chm_pkg::NIL_LINK);
      sts.cur_nil    = (cur_ff == chm_pkg::NIL_LINK);
      sts.key_match  = (key_rdata_ff == key_ff);
      sts.out_free   = ~rsp_valid_ff | rsp_ready;
   end

endmodule

// ----- rtl/chm_ctrl.sv -----
// Controller of the chained hash map: sequences clearing, bucket head read,
// insert, chain walk and unlink. Depends on chm_pkg.
module chm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  chm_pkg::status_type sts,
   output chm_pkg::cmd_type    cmd
);

   chm_pkg::state_type state_ff;
   chm_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= chm_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         chm_pkg::S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = chm_pkg::S_IDLE;
            end
         end
         chm_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = chm_pkg::S_HEAD;
            end
         end
         chm_pkg::S_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in    = chm_pkg::S_DISPATCH;
         end
         chm_pkg::S_DISPATCH: begin
            case (sts.op)
               chm_pkg::OP_INSERT: begin
                  if (sts.pool_empty) begin
                     cmd.set_full = 1'b1;
                  end else begin
                     cmd.ins_wr = 1'b1;
                  end
                  state_in = chm_pkg::S_REPLY;
               end
               chm_pkg::OP_SEARCH, chm_pkg::OP_DELETE: begin
                  cmd.walk_start = 1'b1;
                  state_in       = chm_pkg::S_NODE_RD;
               end
               default: begin
                  state_in = chm_pkg::S_REPLY;
               end
            endcase
         end
         chm_pkg::S_NODE_RD: begin
            if (sts.cur_nil) begin
               state_in = chm_pkg::S_REPLY;
            end else begin
               cmd.node_rd = 1'b1;
               state_in    = chm_pkg::S_NODE_CHK;
            end
         end
         chm_pkg::S_NODE_CHK: begin
            if (!sts.key_match) begin
               cmd.walk_adv = 1'b1;
               state_in     = chm_pkg::S_NODE_RD;
            end else if (sts.op == chm_pkg::OP_SEARCH) begin
               cmd.set_found = 1'b1;
               state_in      = chm_pkg::S_REPLY;
            end else begin
               // splice the match out of its chain
               cmd.del_link = 1'b1;
               state_in     = chm_pkg::S_DEL_FREE;
            end
         end
         chm_pkg::S_DEL_FREE: begin
            cmd.del_free = 1'b1;
            state_in     = chm_pkg::S_REPLY;
         end
         chm_pkg::S_REPLY: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = chm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = chm_pkg::S_IDLE;
         end
      endcase
   end

endmodule
